@@ rtl/core/itda_pkg.sv @@
`timescale 1ns / 1ps
package itda_pkg;

    // field widths
    localparam int BIN_W      = 64;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = 6;
    localparam int NUM_W      = 5;

    // mode codes
    localparam logic [1:0] ACT_S64 = 2'd0;
    localparam logic [1:0] ACT_U64 = 2'd1;
    localparam logic [1:0] ACT_U32 = 2'd2;

    // ascii codes
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef logic [BIN_W-1:0] bin_t;
    typedef logic [BCD_W-1:0] bcd_t;
    typedef logic [7:0]       char_t;

    // conversion unit status toward the formatter
    typedef struct packed {
        logic done;
        logic neg;
        logic busy;
    } dab_res_t;

endpackage

@@ rtl/core/itda_if.sv @@
`timescale 1ns / 1ps
interface itda_in_if;
    logic                   valid;
    logic                   ready;
    logic [63:0]            value;
    logic [1:0]             action;

    modport source (output valid, output value, output action, input ready);
    modport sink   (input valid, input value, input action, output ready);
endinterface

interface itda_out_if;
    logic                   valid;
    logic                   ready;
    logic [7:0]             character;
    logic                   last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

@@ rtl/core/itda_dabble.sv @@
`timescale 1ns / 1ps
module itda_dabble
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  itda_pkg::bin_t    mag,
    input  logic              neg,
    output itda_pkg::dab_res_t res,
    output itda_pkg::bcd_t    bcd
);
    import itda_pkg::*;

    bin_t             bin_reg, bin_next;
    bcd_t             bcd_reg, bcd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             neg_reg, neg_next;
    bcd_t             adj;

    // add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // one binary bit shifted into the bcd register per cycle
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        if (start)
        begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = '1;
            busy_next = 1'b1;
            neg_next  = neg;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_next = {bin_reg[BIN_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign res.done = done_reg;
    assign res.neg  = neg_reg;
    assign res.busy = busy_reg;
    assign bcd      = bcd_reg;

    // done only after the last shift step
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg) && !busy_reg)
        else $error("done without a finished conversion");

    // a new start never lands on a running conversion
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("start while converting");

    // the top and bottom digits are valid bcd digits when done
    a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (bcd_reg[BCD_W-1:BCD_W-4] <= 4'd9) && (bcd_reg[3:0] <= 4'd9))
        else $error("bcd digit out of range");

endmodule

@@ rtl/core/itda_fmt.sv @@
`timescale 1ns / 1ps
module itda_fmt
#(
    parameter int MAX_CHARS = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  itda_pkg::dab_res_t res,
    input  itda_pkg::bcd_t     bcd,
    output logic               busy,
    itda_out_if.source         dout
);
    import itda_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TRIM  = 3'd1;
    localparam logic [2:0] ST_CUT   = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_DIGIT = 3'd4;

    localparam logic [NUM_W-1:0] MAX_N = NUM_W'(MAX_CHARS);

    logic [2:0]       state_reg, state_next;
    bcd_t             dig_reg, dig_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic             neg_reg, neg_next;
    logic             valid_reg, valid_next;
    char_t            char_reg, char_next;
    logic             last_reg, last_next;
    logic [3:0]       top;
    logic             out_free;

    assign top      = dig_reg[BCD_W-1 -: 4];
    assign out_free = !valid_reg || dout.ready;

    // strip leading zeros, then drop characters over the limit, then emit
    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        num_next   = num_reg;
        neg_next   = neg_reg;
        valid_next = valid_reg && !dout.ready;
        char_next  = char_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (res.done)
                begin
                    dig_next   = bcd;
                    num_next   = NUM_W'(NUM_DIGITS);
                    neg_next   = res.neg;
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                if (num_reg > NUM_W'(1) && top == 4'd0)
                begin
                    dig_next = {dig_reg[BCD_W-5:0], 4'd0};
                    num_next = num_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_CUT;
                end
            end
            ST_CUT:
            begin
                priority if (num_reg > MAX_N)
                begin
                    dig_next = {dig_reg[BCD_W-5:0], 4'd0};
                    num_next = num_reg - 1'b1;
                end
                else if (neg_reg && num_reg == MAX_N)
                begin
                    neg_next = 1'b0;
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    char_next  = ASCII_MINUS;
                    last_next  = 1'b0;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    char_next  = ASCII_ZERO + {4'd0, top};
                    last_next  = (num_reg == NUM_W'(1));
                    dig_next   = {dig_reg[BCD_W-5:0], 4'd0};
                    num_next   = num_reg - 1'b1;
                    if (num_reg == NUM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // datapath and output register
    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        num_reg  <= num_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign dout.valid     = valid_reg;
    assign dout.character = char_reg;
    assign dout.last      = last_reg;

    // a result only arrives while the formatter is free
    a_load_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.done |-> state_reg == ST_IDLE)
        else $error("conversion result while formatting");

    // the digit count never runs out while emitting
    a_num_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGN || state_reg == ST_DIGIT) |-> num_reg != '0 && num_reg <= MAX_N)
        else $error("digit count out of range while emitting");

    // the sign leaves room for the digits
    a_sign_fits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SIGN |-> neg_reg && num_reg < MAX_N)
        else $error("sign emitted past the character limit");

    // the emit that returns to idle flags the last character
    a_last_on_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT && state_next == ST_IDLE) |=> valid_reg && last_reg)
        else $error("number ended without last flag");

endmodule

@@ rtl/core/integer_to_decimal_ascii_top.sv @@
`timescale 1ns / 1ps
// conversion runs the bit-serial double dabble of the 64-step shift loop, a registered transfer of the
// bcd result to the formatter, a leading-zero strip and limit cut of one bcd digit a cycle, then the
// sign and digit emit steps; each character is held in the output register until the sink takes it
// one item is in flight at a time: the formatter emits one digit a cycle while the sink is ready,
// and a new item is taken once the last character sits in the output register; reset clears only
// the handshake and sequencer state
module integer_to_decimal_ascii_top
#(
    parameter int MAX_CHARS = 20
)
(
    input  logic       clk,
    input  logic       rst_n,
    itda_in_if.sink    din,
    itda_out_if.source dout
);
    import itda_pkg::*;

    bin_t     mag;
    logic     neg;
    dab_res_t res;
    bcd_t     bcd;
    logic     fmt_busy;

    // mode decode and magnitude of the input value
    always_comb
    begin
        unique case (din.action)
            ACT_S64:
            begin
                neg = din.value[BIN_W-1];
                mag = neg ? (~din.value + 1'b1) : din.value;
            end
            ACT_U64:
            begin
                neg = 1'b0;
                mag = din.value;
            end
            default:
            begin
                neg = 1'b0;
                mag = {32'd0, din.value[31:0]};
            end
        endcase
    end

    // one item in flight at a time
    assign din.ready = !res.busy && !res.done && !fmt_busy;

    itda_dabble u_dabble
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (din.valid && din.ready),
        .mag   (mag),
        .neg   (neg),
        .res   (res),
        .bcd   (bcd)
    );

    itda_fmt #(.MAX_CHARS(MAX_CHARS)) u_fmt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .res   (res),
        .bcd   (bcd),
        .busy  (fmt_busy),
        .dout  (dout)
    );

endmodule

@@ dv/integer_to_decimal_ascii_top_tb.sv @@
`timescale 1ns / 1ps
module integer_to_decimal_ascii_top_tb;
    import itda_pkg::*;

    localparam int TEXT_MAX = 20;
    // spare mode code, decoded like unsigned 32-bit
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int LONG_HOLD = 600;
    localparam int HOLD_AT = 30;
    localparam int CALM_ITEMS = 25;
    localparam int RANDOM_ITEMS = 148;

    typedef struct {
        bin_t       value;
        logic [1:0] action;
        bit         drain;
    } number_req_t;

    typedef struct packed {
        char_t character;
        logic  last;
    } ascii_char_t;

    logic clk = 1'b0;
    logic rst_n;

    itda_in_if  din_if();
    itda_out_if dout_if();

    integer_to_decimal_ascii_top #(.MAX_CHARS(TEXT_MAX)) DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    number_req_t pending_numbers[$];
    ascii_char_t expected_chars[$];
    ascii_char_t want_char;

    int unsigned items_taken;
    int unsigned quiet_from;
    int unsigned send_gap;
    int unsigned sink_gap;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned chars_checked;
    int unsigned numbers_done;
    int unsigned mismatches;

    wire calm = (items_taken >= quiet_from);

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // expected decimal text of one number, one entry per character
    function automatic void predict_text(input bin_t raw, input logic [1:0] mode);
        bin_t        mag;
        logic        neg;
        char_t       text[$];
        ascii_char_t one;
        neg = 1'b0;
        if ((mode & ACT_U32) != 2'b00)
            mag = {32'd0, raw[31:0]};
        else if ((mode & ACT_U64) != 2'b00)
            mag = raw;
        else
        begin
            neg = raw[63];
            mag = neg ? (64'd0 - raw) : raw;
        end
        do
        begin
            text.push_front(ASCII_ZERO + char_t'(mag % 64'd10));
            mag = mag / 64'd10;
        end
        while (mag != 64'd0);
        if (neg)
            text.push_front(ASCII_MINUS);
        // overlong text keeps only the low-order characters
        while (text.size() > TEXT_MAX)
            void'(text.pop_front());
        foreach (text[k])
        begin
            one.character = text[k];
            one.last      = (k == text.size() - 1);
            expected_chars.push_back(one);
        end
    endfunction

    function automatic bin_t pow10(input int unsigned k);
        bin_t p;
        p = 64'd1;
        repeat (k)
            p = p * 64'd10;
        return p;
    endfunction

    function automatic void add_number(input bin_t v, input logic [1:0] a, input bit d);
        number_req_t req;
        req.value  = v;
        req.action = a;
        req.drain  = d;
        pending_numbers.push_back(req);
    endfunction

    // random values weighted toward digit-count and sign boundaries
    function automatic bin_t pick_value();
        bin_t        v;
        bin_t        p;
        int unsigned off;
        p   = pow10($urandom_range(0, 19));
        off = $urandom_range(0, 2);
        case ($urandom_range(0, 7))
            0: v = {$urandom, $urandom};
            1: v = bin_t'($urandom_range(0, 999));
            2: v = p + bin_t'(off) - 64'd1;
            3: v = 64'd0 - bin_t'($urandom_range(1, 999));
            4: v = 64'd0 - (p + bin_t'(off) - 64'd1);
            5: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            6: v = {~$urandom_range(0, 3), $urandom};
            default: v = {$urandom, 32'hFFFF_FFFF - $urandom_range(0, 3)};
        endcase
        return v;
    endfunction

    // driver: offers pending numbers, records each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            din_if.valid  <= 1'b0;
            din_if.value  <= '0;
            din_if.action <= ACT_S64;
            send_gap      <= 0;
            items_taken   <= 0;
        end
        else
        begin
            if (din_if.valid && din_if.ready)
            begin
                predict_text(din_if.value, din_if.action);
                items_taken <= items_taken + 1;
            end
            if (!din_if.valid || din_if.ready)
            begin
                if (send_gap != 0)
                begin
                    din_if.valid <= 1'b0;
                    send_gap     <= send_gap - 1;
                end
                else if (pending_numbers.size() != 0 &&
                         !(pending_numbers[0].drain && expected_chars.size() != 0))
                begin
                    din_if.valid  <= 1'b1;
                    din_if.value  <= pending_numbers[0].value;
                    din_if.action <= pending_numbers[0].action;
                    void'(pending_numbers.pop_front());
                    if (!calm && $urandom_range(0, 4) == 0)
                        send_gap <= $urandom_range(1, 18);
                end
                else
                    din_if.valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && items_taken >= HOLD_AT)
        begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor: checks each character transaction, drives ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_if.ready <= 1'b0;
            sink_gap      <= 0;
        end
        else
        begin
            if (dout_if.valid && dout_if.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected character expected none, actual char %h last %b",
                             $time, dout_if.character, dout_if.last);
                    mismatches++;
                end
                else
                begin
                    want_char = expected_chars.pop_front();
                    if (want_char.character !== dout_if.character ||
                        want_char.last !== dout_if.last)
                    begin
                        $display("%0t: mismatch expected char %h last %b, actual char %h last %b",
                                 $time, want_char.character, want_char.last,
                                 dout_if.character, dout_if.last);
                        mismatches++;
                    end
                end
                chars_checked++;
                if (dout_if.last === 1'b1)
                    numbers_done++;
            end
            if (hold_left != 0)
                dout_if.ready <= 1'b0;
            else if (sink_gap != 0)
            begin
                dout_if.ready <= 1'b0;
                sink_gap      <= sink_gap - 1;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                dout_if.ready <= 1'b0;
                sink_gap      <= $urandom_range(0, 17);
            end
            else
                dout_if.ready <= 1'b1;
        end
    end

    // run limit
    initial
    begin
        #6_000_000;
        $display("FAIL");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        din_if.valid  = 1'b0;
        din_if.value  = '0;
        din_if.action = ACT_S64;
        dout_if.ready = 1'b0;
        chars_checked = 0;
        numbers_done  = 0;
        mismatches    = 0;
        quiet_from    = '1;
        rst_n         = 1'b0;

        // zero in every mode, single digits, digit-count edges
        add_number(64'd0, ACT_S64, 1'b0);
        add_number(64'd0, ACT_U64, 1'b0);
        add_number(64'd0, ACT_U32, 1'b0);
        add_number(64'd1, ACT_S64, 1'b0);
        add_number(64'd9, ACT_U64, 1'b0);
        add_number(64'd10, ACT_U32, 1'b0);
        add_number(64'hFFFF_FFFF_FFFF_FFFF, ACT_U64, 1'b0);
        add_number(64'hFFFF_FFFF_FFFF_FFFF, ACT_S64, 1'b0);
        add_number(64'h7FFF_FFFF_FFFF_FFFF, ACT_S64, 1'b0);
        // most negative signed value, sent once the block has drained
        add_number(64'h8000_0000_0000_0000, ACT_S64, 1'b1);
        add_number(64'h8000_0000_0000_0000, ACT_U64, 1'b0);
        add_number(64'hFFFF_FFFF_FFFF_FFFF, ACT_U32, 1'b0);
        // upper half ignored in 32-bit mode
        add_number(64'h1234_5678_0000_0000, ACT_U32, 1'b0);
        add_number(64'h0000_0000_FFFF_FFFF, ACT_S64, 1'b0);
        // spare mode code behaves as 32-bit
        add_number(64'hFFFF_FFFF_0000_0001, ACT_SPARE, 1'b0);
        add_number(64'hFFFF_FFFF_FFFF_FFFF, ACT_SPARE, 1'b0);
        add_number(pow10(19) - 64'd1, ACT_U64, 1'b0);
        add_number(pow10(19), ACT_U64, 1'b0);
        add_number(64'd0 - pow10(18), ACT_S64, 1'b0);
        add_number(64'd0 - 64'd10, ACT_S64, 1'b0);
        add_number(64'hAAAA_AAAA_5555_5555, ACT_U64, 1'b0);
        add_number(64'h5555_5555_AAAA_AAAA, ACT_S64, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_number(pick_value(), 2'($urandom_range(0, 3)), (i % 45) == 44);
        quiet_from = pending_numbers.size() - CALM_ITEMS;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_numbers.size() != 0 || din_if.valid || expected_chars.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("converted %0d numbers into %0d characters across signed, unsigned and",
                 numbers_done, chars_checked);
        $display("32-bit modes with random stalls and one long output hold, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
